// File: rtl/core/prime_triple_decomposition_assert.svh
// Assertion macros for the prime triple decomposition block.
`ifndef PRIME_TRIPLE_DECOMPOSITION_ASSERT_SVH
`define PRIME_TRIPLE_DECOMPOSITION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, idle during rst.
`define PTD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle during rst.
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PTD_ASSERT_IMPL(label, ante, cons, msg)
`define PTD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/ptd_pkg.sv
// Package: types, codes and constants of the prime triple decomposition block.
package ptd_pkg;

  // Default working width of the number.
  localparam int VALUE_BITS_DEF = 16;
  // Width of the payload fields.
  localparam int FIELD_BITS     = 16;

  // Numbers at or below this are rejected outright.
  localparam int SCREEN_MAX     = 5;
  // The fixed prime taken off n before the pair search.
  localparam int FIXED_PRIME    = 3;
  // First trial divisor and first pair candidate.
  localparam int FIRST_PRIME    = 2;

  typedef enum logic [1:0] {
    STATUS_INVALID = 2'd0,
    STATUS_FOUND   = 2'd1,
    STATUS_NONE    = 2'd2
  } status_t;

  // Which number the current primality test is for.
  typedef enum logic [1:0] {
    TGT_N,
    TGT_A,
    TGT_B
  } target_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCREEN,
    ST_PT_INIT,
    ST_PT_CMP,
    ST_PT_DIV,
    ST_RET,
    ST_NEXT_A,
    ST_DONE
  } state_t;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

// File: rtl/core/ptd_in_if.sv
// Input channel: one number per beat.
interface ptd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink (input valid, input number_in, output ready);
endinterface

// File: rtl/core/ptd_out_if.sv
// Output channel: one decomposition result per beat.
interface ptd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] first_prime;
  logic [15:0] second_prime;

  modport source (output valid, output status, output first_prime, output second_prime,
                  input ready);
  modport sink (input valid, input status, input first_prime, input second_prime,
                output ready);
endinterface

// File: rtl/core/ptd_rem_unit.sv
// Shared remainder unit: restoring division, one quotient bit per cycle.
module ptd_rem_unit #(
  parameter int VALUE_BITS = ptd_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output ptd_pkg::rem_stat_t    stat,
  output logic [VALUE_BITS-1:0] rem
);

  localparam int W  = VALUE_BITS;
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W-1:0]  sh;
  logic [W-1:0]  r;
  logic [W-1:0]  r_next;
  logic [W:0]    trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {r, sh[W-1]};
    if (trial >= {1'b0, divisor}) begin
      r_next = W'(trial - {1'b0, divisor});
    end else begin
      r_next = W'(trial);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      r  <= '0;
    end else if (busy) begin
      sh <= sh << 1;
      r  <= r_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign rem       = r;

endmodule

// File: rtl/core/prime_triple_decomposition.sv
// Top level of the prime triple decomposition block: sequencer, remainder unit, output register.
// Sequence: a screen, then per primality test of x about sqrt(x) divisors,
//   each run through the shared remainder unit; n near 65521 needs full tests
//   of n and of b.
// Throughput: one number at a time; the next is taken once the sequencer is idle,
//   which it reaches as soon as the result sits in the output register.
module prime_triple_decomposition #(
  parameter int VALUE_BITS = ptd_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ptd_in_if.sink    item,
  ptd_out_if.source result
);

`include "prime_triple_decomposition_assert.svh"

  localparam int W  = VALUE_BITS;
  localparam int FB = ptd_pkg::FIELD_BITS;

  ptd_pkg::state_t  state, state_next;
  ptd_pkg::target_t target, target_next;
  ptd_pkg::status_t res_status, res_status_next;

  logic [W-1:0] n, n_next;
  logic [W-1:0] rest, rest_next;
  logic [W-1:0] a, a_next;
  logic [W-1:0] x, x_next;
  logic [W-1:0] d, d_next;
  logic [W:0]   sq, sq_next;
  logic         is_prime, is_prime_next;
  logic [W-1:0] res_first, res_first_next;
  logic [W-1:0] res_second, res_second_next;

  logic         out_valid, out_valid_next;
  logic         load;
  logic [1:0]   out_status;
  logic [FB-1:0] out_first;
  logic [FB-1:0] out_second;

  logic               rem_start;
  ptd_pkg::rem_stat_t rem_stat;
  logic [W-1:0]       rem;
  logic [W+1:0]       found_sum;

  // Shared remainder unit for all trial divisions
  ptd_rem_unit #(.VALUE_BITS(VALUE_BITS)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (x),
    .divisor  (d),
    .stat     (rem_stat),
    .rem      (rem)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    target     <= target_next;
    res_status <= res_status_next;
    n          <= n_next;
    rest       <= rest_next;
    a          <= a_next;
    x          <= x_next;
    d          <= d_next;
    sq         <= sq_next;
    is_prime   <= is_prime_next;
    res_first  <= res_first_next;
    res_second <= res_second_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_first  <= FB'(res_first);
      out_second <= FB'(res_second);
    end
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_next      = state;
    target_next     = target;
    res_status_next = res_status;
    n_next          = n;
    rest_next       = rest;
    a_next          = a;
    x_next          = x;
    d_next          = d;
    sq_next         = sq;
    is_prime_next   = is_prime;
    res_first_next  = res_first;
    res_second_next = res_second;
    rem_start       = 1'b0;
    load            = 1'b0;
    out_valid_next  = out_valid && !result.ready;

    unique case (state)
      ptd_pkg::ST_IDLE: begin
        if (item.valid) begin
          n_next     = W'(item.number_in);
          state_next = ptd_pkg::ST_SCREEN;
        end
      end

      // Reject small or even numbers, else test n itself
      ptd_pkg::ST_SCREEN: begin
        res_first_next  = '0;
        res_second_next = '0;
        if (n <= W'(ptd_pkg::SCREEN_MAX) || !n[0]) begin
          res_status_next = ptd_pkg::STATUS_INVALID;
          state_next      = ptd_pkg::ST_DONE;
        end else begin
          x_next      = n;
          target_next = ptd_pkg::TGT_N;
          state_next  = ptd_pkg::ST_PT_INIT;
        end
      end

      ptd_pkg::ST_PT_INIT: begin
        if (x < W'(ptd_pkg::FIRST_PRIME)) begin
          is_prime_next = 1'b0;
          state_next    = ptd_pkg::ST_RET;
        end else begin
          d_next     = W'(ptd_pkg::FIRST_PRIME);
          sq_next    = (W+1)'(ptd_pkg::FIRST_PRIME * ptd_pkg::FIRST_PRIME);
          state_next = ptd_pkg::ST_PT_CMP;
        end
      end

      // Stop once d*d passes x, else divide
      ptd_pkg::ST_PT_CMP: begin
        if (sq > {1'b0, x}) begin
          is_prime_next = 1'b1;
          state_next    = ptd_pkg::ST_RET;
        end else begin
          rem_start  = 1'b1;
          state_next = ptd_pkg::ST_PT_DIV;
        end
      end

      // (d+1)^2 = d^2 + 2d + 1
      ptd_pkg::ST_PT_DIV: begin
        if (rem_stat.done) begin
          if (rem == '0) begin
            is_prime_next = 1'b0;
            state_next    = ptd_pkg::ST_RET;
          end else begin
            d_next     = d + 1'b1;
            sq_next    = sq + {d, 1'b1};
            state_next = ptd_pkg::ST_PT_CMP;
          end
        end
      end

      // Act on the test result by caller
      ptd_pkg::ST_RET: begin
        unique case (target)
          ptd_pkg::TGT_N: begin
            if (!is_prime) begin
              res_status_next = ptd_pkg::STATUS_INVALID;
              state_next      = ptd_pkg::ST_DONE;
            end else begin
              rest_next  = n - W'(ptd_pkg::FIXED_PRIME);
              a_next     = W'(ptd_pkg::FIRST_PRIME);
              state_next = ptd_pkg::ST_NEXT_A;
            end
          end
          ptd_pkg::TGT_A: begin
            if (is_prime) begin
              x_next      = rest - a;
              target_next = ptd_pkg::TGT_B;
              state_next  = ptd_pkg::ST_PT_INIT;
            end else begin
              a_next     = a + 1'b1;
              state_next = ptd_pkg::ST_NEXT_A;
            end
          end
          ptd_pkg::TGT_B: begin
            if (is_prime) begin
              res_status_next = ptd_pkg::STATUS_FOUND;
              res_first_next  = a;
              res_second_next = rest - a;
              state_next      = ptd_pkg::ST_DONE;
            end else begin
              a_next     = a + 1'b1;
              state_next = ptd_pkg::ST_NEXT_A;
            end
          end
          default: begin
            state_next = ptd_pkg::ST_IDLE;
          end
        endcase
      end

      // Loop while 2a <= n - 3
      ptd_pkg::ST_NEXT_A: begin
        if ({a, 1'b0} <= {1'b0, rest}) begin
          x_next      = a;
          target_next = ptd_pkg::TGT_A;
          state_next  = ptd_pkg::ST_PT_INIT;
        end else begin
          res_status_next = ptd_pkg::STATUS_NONE;
          state_next      = ptd_pkg::ST_DONE;
        end
      end

      // Hand the result over once the output register is free
      ptd_pkg::ST_DONE: begin
        if (!out_valid || result.ready) begin
          load           = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ptd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  assign item.ready          = (state == ptd_pkg::ST_IDLE);
  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.first_prime  = out_first;
  assign result.second_prime = out_second;

  assign found_sum = {2'b00, res_first} + {2'b00, res_second}
                   + (W+2)'(ptd_pkg::FIXED_PRIME);

  `PTD_ASSERT_IMPL(a_rem_done_in_div, rem_stat.done, state == ptd_pkg::ST_PT_DIV,
    "remainder finished outside divide state")
  `PTD_ASSERT_IMPL(a_div_not_stalled, state == ptd_pkg::ST_PT_DIV,
    rem_stat.busy || rem_stat.done, "divide state with idle remainder unit")
  `PTD_ASSERT_IMPL(a_found_sum, load && res_status == ptd_pkg::STATUS_FOUND,
    found_sum == {2'b00, n}, "found pair does not add up to n")
  `PTD_ASSERT_IMPL(a_zero_unless_found, load && res_status != ptd_pkg::STATUS_FOUND,
    res_first == '0 && res_second == '0, "primes nonzero without a found pair")
  `PTD_ASSERT_NEXT(a_accept_screens, item.valid && item.ready,
    state == ptd_pkg::ST_SCREEN, "accepted beat not screened")

endmodule
